// ===== sv/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the soft-clip saturator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, ck, rst_n, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");
// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, ck, rst_n, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define ASSERT_IMPL(label, ck, rst_n, ante, cons)
`define ASSERT_NEXT(label, ck, rst_n, ante, cons)
`endif
`endif

// ===== sv/asc_pkg.sv =====
// Shared types, constants and elaboration-time functions of the soft-clip saturator.
`timescale 1ns / 1ps
package asc_pkg;

	localparam int AMT_W     = 7;
	localparam int AMT_MAX   = 100;
	localparam int PCT_ONE   = 100;
	localparam logic [AMT_W-1:0] AMT_RESET = 7'd20;

	localparam int DRIVE_W   = 19;
	localparam int RCP_W     = 17;
	localparam int MIX_W     = 17;
	localparam int TANH_W    = 20;
	localparam int FRAC_BITS = 22;
	localparam int COEF_W    = 15;

	localparam int POS_THRESH = 734003;
	localparam int NEG_THRESH = -891290;
	localparam logic [COEF_W-1:0] POS_COEF = 15'd19661;
	localparam logic [COEF_W-1:0] NEG_COEF = 15'd9830;

	localparam logic [63:0] Q30_ONE = 64'd1 << 30;

	typedef enum logic [1:0] {
		BR_PASS,
		BR_POS,
		BR_NEG
	} branch_t;

	typedef struct packed {
		logic [DRIVE_W-1:0] drive;
		logic [RCP_W-1:0]   rcp;
		logic [MIX_W-1:0]   amt;
	} cfg_t;

	// e^(-8a) in Q.30 for a in Q.30: 20-term series of e^(-a), then squared three times.
	function automatic logic [63:0] exp_sq_q30(input logic [63:0] a);
		logic [63:0] t;
		logic [63:0] pos;
		logic [63:0] neg;
		logic [63:0] e;
		t   = Q30_ONE;
		pos = Q30_ONE;
		neg = 64'd0;
		t = ((t * a) >> 30) / 64'd1;  neg = neg + t;
		t = ((t * a) >> 30) / 64'd2;  pos = pos + t;
		t = ((t * a) >> 30) / 64'd3;  neg = neg + t;
		t = ((t * a) >> 30) / 64'd4;  pos = pos + t;
		t = ((t * a) >> 30) / 64'd5;  neg = neg + t;
		t = ((t * a) >> 30) / 64'd6;  pos = pos + t;
		t = ((t * a) >> 30) / 64'd7;  neg = neg + t;
		t = ((t * a) >> 30) / 64'd8;  pos = pos + t;
		t = ((t * a) >> 30) / 64'd9;  neg = neg + t;
		t = ((t * a) >> 30) / 64'd10; pos = pos + t;
		t = ((t * a) >> 30) / 64'd11; neg = neg + t;
		t = ((t * a) >> 30) / 64'd12; pos = pos + t;
		t = ((t * a) >> 30) / 64'd13; neg = neg + t;
		t = ((t * a) >> 30) / 64'd14; pos = pos + t;
		t = ((t * a) >> 30) / 64'd15; neg = neg + t;
		t = ((t * a) >> 30) / 64'd16; pos = pos + t;
		t = ((t * a) >> 30) / 64'd17; neg = neg + t;
		t = ((t * a) >> 30) / 64'd18; pos = pos + t;
		t = ((t * a) >> 30) / 64'd19; neg = neg + t;
		t = ((t * a) >> 30) / 64'd20; pos = pos + t;
		e = (neg > pos) ? 64'd0 : pos - neg;
		e = (e * e + (64'd1 << 29)) >> 30;
		e = (e * e + (64'd1 << 29)) >> 30;
		e = (e * e + (64'd1 << 29)) >> 30;
		if (e > Q30_ONE) begin
			e = Q30_ONE;
		end
		return e;
	endfunction

endpackage

// ===== sv/asc_cfg.sv =====
// Amount register and the drive, reciprocal and mix coefficient tables it selects.
`timescale 1ns / 1ps
module asc_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [asc_pkg::AMT_W-1:0] cfg_wr_data,
	output asc_pkg::cfg_t             cfg
);
	import asc_pkg::*;

	logic [AMT_W-1:0]   amount_q;
	logic [AMT_W-1:0]   pct;
	logic [DRIVE_W-1:0] drive_tbl [0:AMT_MAX];
	logic [RCP_W-1:0]   rcp_tbl   [0:AMT_MAX];
	logic [MIX_W-1:0]   amt_tbl   [0:AMT_MAX];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amount_q <= AMT_RESET;
		end else if (cfg_wr_en) begin
			amount_q <= cfg_wr_data;
		end
	end

	// Q.16 drive, its reciprocal and the wet share, one entry per percent.
	for (genvar i = 0; i <= AMT_MAX; i++) begin : g_tbl
		localparam int D = PCT_ONE + 3 * i;
		assign drive_tbl[i] = DRIVE_W'((D * 65536 + PCT_ONE / 2) / PCT_ONE);
		assign rcp_tbl[i]   = RCP_W'((PCT_ONE * 65536 + D / 2) / D);
		assign amt_tbl[i]   = MIX_W'((i * 65536 + PCT_ONE / 2) / PCT_ONE);
	end

	// Clamp anything above full scale.
	assign pct = (amount_q > AMT_W'(AMT_MAX)) ? AMT_W'(AMT_MAX) : amount_q;

	assign cfg.drive = drive_tbl[pct];
	assign cfg.rcp   = rcp_tbl[pct];
	assign cfg.amt   = amt_tbl[pct];

endmodule

// ===== sv/asc_tanh_rom.sv =====
// Interpolation ROM for tanh over [0,4], built at elaboration, registered read.
`timescale 1ns / 1ps
module asc_tanh_rom #(
	parameter int ENTRIES = 256
) (
	input  logic                               clk,
	input  logic                               en,
	input  logic [$clog2(ENTRIES)-1:0]         addr,
	output logic [asc_pkg::TANH_W-1:0]         lo_s4,
	output logic signed [asc_pkg::TANH_W:0]    dlt_s4,
	output logic [asc_pkg::TANH_W-1:0]         last
);
	import asc_pkg::*;

	localparam int PIW = $clog2(ENTRIES + 1);

	logic [TANH_W-1:0] pt [0:ENTRIES];
	logic [PIW-1:0]    a0;
	logic [PIW-1:0]    a1;

	// Point k holds tanh(4k/N) = (1-E)/(1+E) with E = e^(-8k/N), rounded to Q.20.
	for (genvar k = 0; k <= ENTRIES; k++) begin : g_pt
		localparam logic [63:0] A = (64'(k) << 30) / ENTRIES;
		localparam logic [63:0] E = exp_sq_q30(A);
		localparam logic [63:0] V = (((Q30_ONE - E) << 20) + (Q30_ONE + E) / 2) / (Q30_ONE + E);
		assign pt[k] = TANH_W'(V);
	end

	assign a0   = PIW'(addr);
	assign a1   = a0 + PIW'(1);
	assign last = pt[ENTRIES];

	always_ff @(posedge clk) begin
		if (en) begin
			lo_s4  <= pt[a0];
			dlt_s4 <= $signed({1'b0, pt[a1]}) - $signed({1'b0, pt[a0]});
		end
	end

endmodule

// ===== sv/asymmetric_soft_clip_saturator.sv =====
// Top level of the asymmetric tanh soft-clip saturator: nine-stage sample pipeline.
`timescale 1ns / 1ps
`include "assert_macros.svh"
//
//  channel   | handshake                     | word
//  ----------+-------------------------------+------------------------------------
//  config    | cfg_wr_en                     | cfg_wr_data (amount, percent)
//  input     | in_valid / in_stall (out)     | in_sample  (signed Q4.20)
//  output    | out_valid / out_stall (in)    | out_sample (signed Q4.20)
//
//  One word per cycle sustained while out_stall is low; nine register stages, among them
//  the multiply stages (drive, interpolation, shaping, reciprocal, mix).
//  Reset clears the stage valid bits and loads amount = 20 percent; the tanh ROM is
//  constant, so no clearing pass is needed and words are taken right after reset.
//  A stall on the output holds only the stages that are full: bubbles collapse, and
//  in_stall rises only once every stage holds a word and out_stall is high.
//
module asymmetric_soft_clip_saturator #(
	parameter int TANH_TABLE_ENTRIES = 256,
	parameter int SAMPLE_BITS        = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [asc_pkg::AMT_W-1:0]     cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] in_sample,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] out_sample
);
	import asc_pkg::*;

	localparam int NSTG = 9;
	localparam int S    = SAMPLE_BITS;
	localparam int PW   = S + DRIVE_W + 1;          // drive product
	localparam int EW   = S + 8;                    // driven sample and wet sample
	localparam int IW   = $clog2(TANH_TABLE_ENTRIES);
	localparam int SCW  = FRAC_BITS + IW;           // argument times table size
	localparam int IPW  = TANH_W + FRAC_BITS + 2;   // interpolation product
	localparam int TSW  = TANH_W + 2;
	localparam int SHW  = TANH_W + COEF_W;          // shaping product
	localparam int YW   = 22;                       // shaped value
	localparam int YRW  = YW + RCP_W + 1;           // reciprocal product
	localparam int MW   = EW + MIX_W + 2;           // mix product

	localparam logic signed [EW-1:0] POS_T   = EW'(POS_THRESH);
	localparam logic signed [EW-1:0] NEG_T   = EW'(NEG_THRESH);
	localparam logic signed [EW-1:0] ARG_LIM = EW'(4 << 20);
	localparam logic signed [YW-1:0] POS_Y   = YW'(POS_THRESH);
	localparam logic signed [YW-1:0] NEG_Y   = YW'(NEG_THRESH);
	localparam logic signed [MW-1:0] SMAX    = MW'({1'b0, {(S - 1){1'b1}}});
	localparam logic signed [MW-1:0] SMIN    = -SMAX - MW'(1);

	cfg_t cfg;

	// Stage control: valid bits travel with the words, ready ripples back.
	logic [NSTG:1] vld_q;
	logic [NSTG:1] vin;
	logic [NSTG:1] rdy;
	logic [NSTG:1] en;

	// Stage payloads.
	logic signed [S-1:0]       x_s1, x_s2, x_s3, x_s4, x_s5, x_s6, x_s7, x_s8;
	logic signed [PW-1:0]      prod_s1;
	branch_t                   br_s2, br_s3, br_s4, br_s5, br_s6;
	logic                      sat_s2, sat_s3, sat_s4;
	logic [FRAC_BITS-1:0]      arg_s2;
	logic [IW-1:0]             idx_s3;
	logic [FRAC_BITS-1:0]      frac_s3, frac_s4;
	logic [TANH_W-1:0]         lo_s4;
	logic signed [TANH_W:0]    dlt_s4;
	logic [TANH_W-1:0]         tanh_last;
	logic [TANH_W-1:0]         t_s5;
	logic signed [YW-1:0]      y_s6;
	logic signed [EW-1:0]      wet_s7;
	logic signed [MW-1:0]      mix_s8;
	logic signed [S-1:0]       smp_s9;

	// Combinational stage logic.
	logic signed [DRIVE_W:0]   drv_sx;
	logic signed [PW-1:0]      mult1;
	logic signed [PW-1:0]      rnd1;
	logic signed [EW-1:0]      dr;
	logic signed [EW-1:0]      u_pos;
	logic signed [EW-1:0]      m_neg;
	logic signed [EW-1:0]      v_neg;
	logic signed [EW-1:0]      arg;
	branch_t                   br;
	logic [SCW-1:0]            scaled;
	logic signed [IPW-1:0]     ip;
	logic signed [TSW-1:0]     tsum;
	logic [COEF_W-1:0]         coef;
	logic [SHW-1:0]            sh;
	logic signed [YW-1:0]      r6;
	logic signed [YRW-1:0]     mult7;
	logic signed [YRW-1:0]     rnd7;
	logic signed [EW:0]        diff;
	logic signed [MW-1:0]      rnd9;
	logic signed [MW-1:0]      o9;

	asc_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cfg         (cfg)
	);

	// Advance a stage when it is empty or the one after it advances.
	always_comb begin
		rdy[NSTG] = !vld_q[NSTG] || !out_stall;
		for (int k = NSTG - 1; k >= 1; k--) begin
			rdy[k] = !vld_q[k] || rdy[k + 1];
		end
	end

	assign vin       = {vld_q[NSTG-1:1], in_valid};
	assign en        = rdy & vin;
	assign in_stall  = !rdy[1];
	assign out_valid = vld_q[NSTG];
	assign out_sample = smp_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= (rdy & vin) | (~rdy & vld_q);
		end
	end

	// Stage 1: drive the sample.
	assign drv_sx = $signed({1'b0, cfg.drive});
	assign mult1  = PW'(in_sample) * PW'(drv_sx);

	// Stage 2: round the driven value, pick the branch, form the tanh argument.
	always_comb begin
		rnd1  = prod_s1 + PW'(32768);
		dr    = EW'(rnd1 >>> 16);
		u_pos = (dr - POS_T) <<< 1;
		m_neg = NEG_T - dr;
		v_neg = (m_neg + (m_neg <<< 1) + EW'(1)) >>> 1;
		priority if (dr >= POS_T) begin
			br  = BR_POS;
			arg = u_pos;
		end else if (dr <= NEG_T) begin
			br  = BR_NEG;
			arg = v_neg;
		end else begin
			br  = BR_PASS;
			arg = '0;
		end
	end

	// Stage 3: split argument into table index and fraction.
	assign scaled = SCW'(arg_s2) * SCW'(TANH_TABLE_ENTRIES);

	// Stage 4: table read.
	asc_tanh_rom #(
		.ENTRIES (TANH_TABLE_ENTRIES)
	) u_rom (
		.clk    (clk),
		.en     (en[4]),
		.addr   (idx_s3),
		.lo_s4  (lo_s4),
		.dlt_s4 (dlt_s4),
		.last   (tanh_last)
	);

	// Stage 5: linear interpolation, fraction product floored.
	assign ip   = IPW'(dlt_s4) * IPW'($signed({1'b0, frac_s4}));
	assign tsum = TSW'($signed({1'b0, lo_s4})) + TSW'(ip >>> FRAC_BITS);

	// Stage 6: scale tanh and offset from the threshold.
	assign coef = (br_s5 == BR_NEG) ? NEG_COEF : POS_COEF;
	assign sh   = SHW'(t_s5) * SHW'(coef);
	assign r6   = YW'((sh + SHW'(32768)) >> 16);

	// Stage 7: divide by drive through the reciprocal.
	assign mult7 = YRW'(y_s6) * YRW'($signed({1'b0, cfg.rcp}));
	assign rnd7  = (mult7 + YRW'(32768)) >>> 16;

	// Stage 8: wet minus dry, times the wet share.
	assign diff = (EW + 1)'(wet_s7) - (EW + 1)'(x_s7);

	// Stage 9: add back the dry sample and clamp.
	assign rnd9 = (mix_s8 + MW'(32768)) >>> 16;
	assign o9   = MW'(x_s8) + rnd9;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			x_s1    <= in_sample;
			prod_s1 <= mult1;
		end
		if (en[2]) begin
			x_s2   <= x_s1;
			br_s2  <= br;
			sat_s2 <= (br != BR_PASS) && (arg >= ARG_LIM);
			arg_s2 <= arg[FRAC_BITS-1:0];
		end
		if (en[3]) begin
			x_s3    <= x_s2;
			br_s3   <= br_s2;
			sat_s3  <= sat_s2;
			idx_s3  <= scaled[SCW-1:FRAC_BITS];
			frac_s3 <= scaled[FRAC_BITS-1:0];
		end
		if (en[4]) begin
			x_s4    <= x_s3;
			br_s4   <= br_s3;
			sat_s4  <= sat_s3;
			frac_s4 <= frac_s3;
		end
		if (en[5]) begin
			x_s5  <= x_s4;
			br_s5 <= br_s4;
			t_s5  <= sat_s4 ? tanh_last : TANH_W'(tsum);
		end
		if (en[6]) begin
			x_s6  <= x_s5;
			br_s6 <= br_s5;
			y_s6  <= (br_s5 == BR_NEG) ? NEG_Y - r6 : POS_Y + r6;
		end
		if (en[7]) begin
			x_s7   <= x_s6;
			wet_s7 <= (br_s6 == BR_PASS) ? EW'(x_s6) : EW'(rnd7);
		end
		if (en[8]) begin
			x_s8   <= x_s7;
			mix_s8 <= MW'(diff) * MW'($signed({1'b0, cfg.amt}));
		end
		if (en[9]) begin
			priority if (o9 > SMAX) begin
				smp_s9 <= S'(SMAX);
			end else if (o9 < SMIN) begin
				smp_s9 <= S'(SMIN);
			end else begin
				smp_s9 <= S'(o9);
			end
		end
	end

	// The input backs up only when the whole pipe is full and the output is held.
	`ASSERT_IMPL(a_stall_full, clk, arst_n, in_stall, out_valid && out_stall && (&vld_q))
	// A word reaches the output only from the last inner stage.
	`ASSERT_IMPL(a_out_from_s8, clk, arst_n, $rose(out_valid), $past(vld_q[NSTG-1]))
	// A free output register always takes the word waiting in front of it.
	`ASSERT_NEXT(a_out_load, clk, arst_n, vld_q[NSTG-1] && rdy[NSTG], out_valid)

endmodule

// ===== bench/asymmetric_soft_clip_saturator_test.sv =====
// Self-checking bench for the asymmetric soft-clip saturator: predicted words vs. DUT output.
`timescale 1ns / 1ps

module asymmetric_soft_clip_saturator_test;

	localparam int SAMPLE_BITS = 24;
	localparam int TANH_POINTS = 256;
	localparam int INTERP_BITS = 22;
	localparam int PIPE_DEPTH = 9;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES = 120;
	localparam int MAX_REPORTS = 10;

	// Knees of the transfer curve in Q.20 and the tanh weights in Q.16.
	localparam longint KNEE_POS = 734003;
	localparam longint KNEE_NEG = -891290;
	localparam longint WEIGHT_POS = 19661;
	localparam longint WEIGHT_NEG = 9830;
	localparam longint unsigned UNITY_Q30 = 64'd1 << 30;

	localparam longint SAMPLE_MAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
	localparam longint SAMPLE_MIN = -(64'sd1 <<< (SAMPLE_BITS - 1));

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [asc_pkg::AMT_W-1:0] cfg_wr_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [SAMPLE_BITS-1:0] in_sample = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [SAMPLE_BITS-1:0] out_sample;

	// Amount currently held by the block, mirrored on every register write.
	logic [asc_pkg::AMT_W-1:0] amount_pct = asc_pkg::AMT_RESET;

	// Words still owed by the block, oldest first.
	logic signed [SAMPLE_BITS-1:0] owed_words[$];

	longint tanh_points [0:TANH_POINTS];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_request = 1'b0;
	int hold_left = 0;
	int mismatch_count = 0;
	int quiet_cycles = 0;

	asymmetric_soft_clip_saturator #(
		.TANH_TABLE_ENTRIES(TANH_POINTS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_sample(in_sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_sample(out_sample)
	);

	always #10 clk = ~clk;

	// ---------------------------------------------------------------- prediction

	// Round half up after an arithmetic right shift (floor semantics on negatives).
	function automatic longint round_shr(input longint v, input int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	// e^(-a), a in Q.30 within [0,1]: truncated 20-term series, alternating sums.
	function automatic longint unsigned exp_neg_q30(input longint unsigned a);
		longint unsigned term;
		longint unsigned sum_even;
		longint unsigned sum_odd;
		longint unsigned k;
		term = UNITY_Q30;
		sum_even = UNITY_Q30;
		sum_odd = 64'd0;
		for (k = 1; k <= 20; k++) begin
			term = ((term * a) >> 30) / k;
			if (k % 2 == 1) begin
				sum_odd += term;
			end else begin
				sum_even += term;
			end
		end
		return (sum_odd > sum_even) ? 64'd0 : sum_even - sum_odd;
	endfunction

	// Fill the tanh table over [0,4]: tanh = (1-E)/(1+E), E = e^(-8k/N) by squaring thrice.
	function automatic void build_tanh_points();
		longint unsigned k;
		longint unsigned e;
		int i;
		for (k = 0; k <= TANH_POINTS; k++) begin
			e = exp_neg_q30((k << 30) / TANH_POINTS);
			for (i = 0; i < 3; i++) begin
				e = (e * e + (64'd1 << 29)) >> 30;
			end
			if (e > UNITY_Q30) begin
				e = UNITY_Q30;
			end
			tanh_points[k] = longint'((((UNITY_Q30 - e) << 20) + (UNITY_Q30 + e) / 2)
				/ (UNITY_Q30 + e));
		end
	endfunction

	// tanh of a nonnegative Q.20 argument by linear interpolation, clamped at tanh(4).
	function automatic longint tanh_interp(input longint v);
		longint scaled;
		longint idx;
		longint frac;
		longint lo;
		longint hi;
		if (v < 0) begin
			v = 0;
		end
		if (v >= (64'sd4 <<< 20)) begin
			return tanh_points[TANH_POINTS];
		end
		scaled = v * TANH_POINTS;
		idx = scaled >>> INTERP_BITS;
		frac = scaled & ((64'sd1 <<< INTERP_BITS) - 1);
		if (idx >= TANH_POINTS) begin
			return tanh_points[TANH_POINTS];
		end
		lo = tanh_points[idx];
		hi = tanh_points[idx + 1];
		return lo + (((hi - lo) * frac) >>> INTERP_BITS);
	endfunction

	// Drive in Q.16 for a register value; values above 100 act as 100.
	function automatic longint drive_q16(input logic [asc_pkg::AMT_W-1:0] pct);
		longint p;
		p = (pct > 100) ? 100 : pct;
		return ((100 + 3 * p) * 65536 + 50) / 100;
	endfunction

	// Input words whose driven value lands on the upper or lower knee.
	function automatic longint knee_word(input logic [asc_pkg::AMT_W-1:0] pct, input bit upper);
		return ((upper ? KNEE_POS : KNEE_NEG) * 65536) / drive_q16(pct);
	endfunction

	// Expected output word for one input word at a given amount.
	function automatic logic signed [SAMPLE_BITS-1:0] soft_clip_word(
		input logic signed [SAMPLE_BITS-1:0] word_in,
		input logic [asc_pkg::AMT_W-1:0] pct
	);
		longint x;
		longint p;
		longint d;
		longint rcp;
		longint mix;
		longint driven;
		longint shaped;
		longint wet;
		longint mixed;
		x = word_in;
		p = (pct > 100) ? 100 : pct;
		d = 100 + 3 * p;
		rcp = (6553600 + d / 2) / d;
		mix = (p * 65536 + 50) / 100;
		driven = round_shr(x * drive_q16(pct), 16);
		if (driven >= KNEE_POS) begin
			shaped = KNEE_POS + round_shr(tanh_interp(2 * (driven - KNEE_POS)) * WEIGHT_POS, 16);
			wet = round_shr(shaped * rcp, 16);
		end else if (driven <= KNEE_NEG) begin
			shaped = KNEE_NEG - round_shr(
				tanh_interp((3 * (KNEE_NEG - driven) + 1) >>> 1) * WEIGHT_NEG, 16);
			wet = round_shr(shaped * rcp, 16);
		end else begin
			wet = x;
		end
		mixed = x + round_shr((wet - x) * mix, 16);
		if (mixed > SAMPLE_MAX) begin
			mixed = SAMPLE_MAX;
		end
		if (mixed < SAMPLE_MIN) begin
			mixed = SAMPLE_MIN;
		end
		return mixed[SAMPLE_BITS-1:0];
	endfunction

	// ---------------------------------------------------------------- output side

	// Stall the output at random, or hold it off entirely while a long hold is running.
	always @(negedge clk) begin
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	// Compare every accepted output word with the oldest owed word.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (owed_words.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS) begin
					$display("unexpected output word %0d with nothing owed", out_sample);
				end
			end else begin
				if (out_sample !== owed_words[0]) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS) begin
						$display("out_sample mismatch: expected %0d, got %0d",
							owed_words[0], out_sample);
					end
				end
				void'(owed_words.pop_front());
			end
		end
	end

	// Abort when no word moves on either channel for too long.
	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("[asymmetric_soft_clip_saturator] ERROR");
		$finish;
	end

	// ---------------------------------------------------------------- input side

	// Offer one word after a random idle stretch; hold it until accepted, then owe its result.
	task automatic offer_word(input logic signed [SAMPLE_BITS-1:0] word_in);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_sample <= word_in;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		owed_words.insert(owed_words.size(), soft_clip_word(word_in, amount_pct));
		@(negedge clk);
	endtask

	// Drop valid and wait for every owed word, then for a margin scaled from PIPE_DEPTH.
	task automatic drain_pipeline();
		in_valid <= 1'b0;
		while (owed_words.size() != 0) begin
			@(negedge clk);
		end
		repeat (PIPE_DEPTH + 3) @(negedge clk);
	endtask

	// Write the amount register while the block is idle.
	task automatic write_amount(input logic [asc_pkg::AMT_W-1:0] pct);
		drain_pipeline();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= pct;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		amount_pct = pct;
	endtask

	// Random word: full range, around unity, or close to one of the knees.
	function automatic logic signed [SAMPLE_BITS-1:0] pick_word();
		int sel;
		longint v;
		sel = $urandom_range(0, 9);
		if (sel < 4) begin
			v = longint'($urandom);
		end else if (sel < 7) begin
			v = longint'($urandom_range(0, 2516582)) - 1258291;
		end else begin
			v = knee_word(amount_pct, 1'($urandom_range(0, 1)))
				+ longint'($urandom_range(0, 4000)) - 2000;
		end
		return v[SAMPLE_BITS-1:0];
	endfunction

	// ---------------------------------------------------------------- tests

	// Field extremes and both knees at the reset amount of 20 percent.
	task automatic test_reset_amount();
		int i;
		offer_word(24'sd0);
		offer_word(24'sd1);
		offer_word(-24'sd1);
		offer_word(SAMPLE_MAX[SAMPLE_BITS-1:0]);
		offer_word(SAMPLE_MIN[SAMPLE_BITS-1:0]);
		for (i = -1; i <= 1; i++) begin
			offer_word(SAMPLE_BITS'(knee_word(amount_pct, 1'b1) + i));
			offer_word(SAMPLE_BITS'(knee_word(amount_pct, 1'b0) + i));
		end
	endtask

	// Amount zero passes words through; full and above-range amounts clip hardest.
	task automatic test_amount_limits();
		write_amount(7'd0);
		offer_word(SAMPLE_MAX[SAMPLE_BITS-1:0]);
		offer_word(SAMPLE_MIN[SAMPLE_BITS-1:0]);
		offer_word(24'sd12345);
		write_amount(7'd100);
		offer_word(SAMPLE_MAX[SAMPLE_BITS-1:0]);
		offer_word(SAMPLE_MIN[SAMPLE_BITS-1:0]);
		offer_word(SAMPLE_BITS'(knee_word(amount_pct, 1'b1)));
		offer_word(SAMPLE_BITS'(knee_word(amount_pct, 1'b0)));
		write_amount(7'd127);
		offer_word(SAMPLE_MAX[SAMPLE_BITS-1:0]);
		offer_word(SAMPLE_MIN[SAMPLE_BITS-1:0]);
		offer_word(SAMPLE_BITS'(knee_word(amount_pct, 1'b1)));
	endtask

	// One phase of random words at a given amount and idle mix.
	task automatic test_random_traffic(
		input int count,
		input int send_pct,
		input int stall_pct,
		input logic [asc_pkg::AMT_W-1:0] pct
	);
		int n;
		write_amount(pct);
		send_idle_pct = send_pct;
		recv_stall_pct = stall_pct;
		for (n = 0; n < count; n++) begin
			offer_word(pick_word());
		end
	endtask

	// Hold the output off for a long stretch while words keep coming, so the input stalls.
	task automatic test_output_backpressure();
		int n;
		drain_pipeline();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_request = 1'b1;
		for (n = 0; n < 40; n++) begin
			offer_word(pick_word());
		end
	endtask

	initial begin
		build_tanh_points();
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_amount();
		test_amount_limits();
		test_random_traffic(174, 0, 0, 7'd50);
		test_random_traffic(174, 61, 0, 7'd100);
		test_random_traffic(174, 0, 61, 7'd7);
		test_random_traffic(174, 22, 22, 7'($urandom_range(0, 127)));
		test_output_backpressure();
		test_random_traffic(174, 0, 0, 7'd127);
		test_random_traffic(174, 61, 0, 7'd0);
		test_random_traffic(174, 22, 22, 7'($urandom_range(0, 127)));

		drain_pipeline();
		repeat (PIPE_DEPTH * 2) @(negedge clk);
		if (mismatch_count == 0 && owed_words.size() == 0) begin
			$display("[asymmetric_soft_clip_saturator] OK");
		end else begin
			$display("[asymmetric_soft_clip_saturator] ERROR");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+sv
sv/asc_pkg.sv
sv/asc_cfg.sv
sv/asc_tanh_rom.sv
sv/asymmetric_soft_clip_saturator.sv
bench/asymmetric_soft_clip_saturator_test.sv
